/* rtl/core/frame_checker_crc32_top_defines.svh */
// assertion macros for the frame checker rtl
// expects clk and arst_n in the module that uses them
`ifndef FRAME_CHECKER_CRC32_TOP_DEFINES_SVH
`define FRAME_CHECKER_CRC32_TOP_DEFINES_SVH

`ifndef SYNTH
// checked on every edge outside reset
`define FCC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("frame checker assertion failed");
// checked on every edge, reset included
`define FCC_ASSERT_ALWAYS(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("frame checker assertion failed");
`else
`define FCC_ASSERT(lbl, prop)
`define FCC_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

/* rtl/core/fcc_pkg.sv */
// shared types, constants and the crc byte update for the frame checker
// no dependencies
`default_nettype none

package fcc_pkg;

	localparam logic [16:0] COUNT_MAX      = 17'h1FFFF;
	localparam int unsigned HEADER_BYTES   = 8;
	localparam int unsigned OVERHEAD_BYTES = 12;
	localparam int unsigned CRC_TAP_POS    = 4;
	localparam logic [31:0] CRC_POLY       = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT       = 32'hFFFFFFFF;
	localparam int unsigned QUEUE_DEPTH    = 4;
	localparam int unsigned CFG_INDEX_W    = 2;
	localparam int unsigned CFG_DATA_W     = 8;

	// result kinds
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	// register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_ID      = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_VERSION = 2'd1;

	typedef enum logic [2:0] {
		STATUS_OK         = 3'd0,
		STATUS_TOO_SHORT  = 3'd1,
		STATUS_BAD_ID_VER = 3'd2,
		STATUS_LEN_MISM   = 3'd3,
		STATUS_CRC_MISM   = 3'd4
	} status_t;

	// one queued result, raw: the verdict is decided on the way out
	typedef struct packed {
		logic        kind;
		logic [7:0]  data;
		logic [16:0] total;
		logic [63:0] header;
		logic [31:0] crc;
		logic [31:0] tail;
	} fcc_entry_t;

	typedef struct packed {
		logic                   we;
		logic [CFG_INDEX_W-1:0] index;
		logic [CFG_DATA_W-1:0]  data;
	} fcc_cfg_t;

	// reflected crc-32, one byte, lsb first
	function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'h0, b};
		for (int k = 0; k < 8; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/fcc_front.sv */
// front end: takes frame bytes, tracks header, crc and tail, classifies each byte
// uses fcc_pkg and the assertion macros
`default_nettype none
`include "frame_checker_crc32_top_defines.svh"

module fcc_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic [7:0]          rx_byte,
	input  wire logic                frame_end,
	input  wire logic                push,
	output logic                     full,
	output logic                     q_push,
	output fcc_pkg::fcc_entry_t      q_entry,
	input  wire logic                q_full
);

	logic [16:0] count_q;
	logic [63:0] header_q;
	logic [31:0] crc_q;
	logic [31:0] tail_q;

	logic        accept;
	logic [63:0] header_nx;
	logic [31:0] crc_nx;
	logic [31:0] tail_nx;
	logic [16:0] count_nx;
	logic [16:0] payload_off;
	logic [15:0] len;
	logic        fwd;
	logic [5:0]  lane_lsb;

	assign full   = q_full;
	assign accept = push && !q_full;

	// per-byte state update and classification
	always_comb begin
		lane_lsb  = {3'd7 - count_q[2:0], 3'b000};
		header_nx = header_q;
		if (count_q < 17'(fcc_pkg::HEADER_BYTES)) begin
			header_nx[lane_lsb +: 8] = rx_byte;
		end
		crc_nx   = (count_q >= 17'(fcc_pkg::CRC_TAP_POS)) ?
			fcc_pkg::crc32_byte(crc_q, tail_q[31:24]) : crc_q;
		tail_nx  = {tail_q[23:0], rx_byte};
		count_nx = (count_q != fcc_pkg::COUNT_MAX) ? count_q + 17'd1 : count_q;
		len         = header_nx[15:0];
		payload_off = count_q - 17'(fcc_pkg::HEADER_BYTES);
		fwd = (count_q >= 17'(fcc_pkg::HEADER_BYTES)) && (payload_off < {1'b0, len});
	end

	// queue entry
	always_comb begin
		q_entry.kind   = frame_end ? fcc_pkg::KIND_VERDICT : fcc_pkg::KIND_PAYLOAD;
		q_entry.data   = frame_end ? 8'h00 : rx_byte;
		q_entry.total  = count_nx;
		q_entry.header = header_nx;
		q_entry.crc    = crc_nx;
		q_entry.tail   = tail_nx;
		q_push = accept && (frame_end || fwd);
	end

	// frame state, cleared after every verdict
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			header_q <= '0;
			crc_q    <= fcc_pkg::CRC_INIT;
			tail_q   <= '0;
		end else if (accept) begin
			if (frame_end) begin
				count_q  <= '0;
				header_q <= '0;
				crc_q    <= fcc_pkg::CRC_INIT;
				tail_q   <= '0;
			end else begin
				count_q  <= count_nx;
				header_q <= header_nx;
				crc_q    <= crc_nx;
				tail_q   <= tail_nx;
			end
		end
	end

	// checks
	`FCC_ASSERT(a_clear_after_end, (accept && frame_end) |=> (count_q == '0 && crc_q == fcc_pkg::CRC_INIT))
	`FCC_ASSERT(a_end_gives_verdict, (accept && frame_end) |-> (q_push && q_entry.kind == fcc_pkg::KIND_VERDICT))
	`FCC_ASSERT(a_no_push_when_full, q_full |-> !q_push)

endmodule

`default_nettype wire

/* rtl/core/fcc_queue.sv */
// short queue between the front end and the result side
// uses fcc_pkg for the entry type and the assertion macros
`default_nettype none
`include "frame_checker_crc32_top_defines.svh"

module fcc_queue #(
	parameter int unsigned DEPTH = fcc_pkg::QUEUE_DEPTH
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire fcc_pkg::fcc_entry_t entry_in,
	output logic                     full,
	input  wire logic                pop,
	output logic                     empty,
	output fcc_pkg::fcc_entry_t      entry_out
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	fcc_pkg::fcc_entry_t mem_q [DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [CNT_W-1:0]    count_q;
	logic                do_push;
	logic                do_pop;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign empty     = (count_q == '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && !empty;
	assign entry_out = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= entry_in;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// checks
	`FCC_ASSERT(a_count_bound, count_q <= CNT_W'(DEPTH))
	`FCC_ASSERT(a_count_up, (do_push && !do_pop) |=> count_q == CNT_W'($past(count_q) + 1'b1))

endmodule

`default_nettype wire

/* rtl/core/fcc_back.sv */
// result side: holds the id and version registers and decides the verdict
// uses fcc_pkg
`default_nettype none

module fcc_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire fcc_pkg::fcc_cfg_t   cfg,
	input  wire fcc_pkg::fcc_entry_t entry,
	output logic                     kind,
	output logic [7:0]               payload_byte,
	output logic [2:0]               status,
	output logic [15:0]              seq_number,
	output logic [15:0]              frame_total,
	output logic [15:0]              declared_length
);

	logic [7:0]       exp_id_q;
	logic [7:0]       exp_ver_q;
	fcc_pkg::status_t st;
	logic [16:0]      want_total;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_id_q  <= '0;
			exp_ver_q <= '0;
		end else if (cfg.we) begin
			case (cfg.index)
				fcc_pkg::REG_EXPECTED_ID:      exp_id_q  <= cfg.data;
				fcc_pkg::REG_EXPECTED_VERSION: exp_ver_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// checks in priority order
	always_comb begin
		want_total = 17'(fcc_pkg::OVERHEAD_BYTES) + {1'b0, entry.header[15:0]};
		if (entry.total < 17'(fcc_pkg::OVERHEAD_BYTES)) begin
			st = fcc_pkg::STATUS_TOO_SHORT;
		end else if (entry.header[63:56] != exp_id_q || entry.header[55:48] != exp_ver_q) begin
			st = fcc_pkg::STATUS_BAD_ID_VER;
		end else if (entry.total != want_total) begin
			st = fcc_pkg::STATUS_LEN_MISM;
		end else if ((entry.crc ^ fcc_pkg::CRC_INIT) != entry.tail) begin
			st = fcc_pkg::STATUS_CRC_MISM;
		end else begin
			st = fcc_pkg::STATUS_OK;
		end
	end

	// result fields, zero where the kind does not use them
	always_comb begin
		kind         = entry.kind;
		payload_byte = entry.data;
		if (entry.kind == fcc_pkg::KIND_VERDICT) begin
			status          = st;
			seq_number      = entry.header[47:32];
			frame_total     = entry.header[31:16];
			declared_length = entry.header[15:0];
		end else begin
			status          = fcc_pkg::STATUS_OK;
			seq_number      = '0;
			frame_total     = '0;
			declared_length = '0;
		end
	end

endmodule

`default_nettype wire

/* rtl/core/frame_checker_crc32_top.sv */
// frame checker top: front end, result queue and verdict stage
// uses fcc_pkg, fcc_front, fcc_queue and fcc_back
//
// Frame bytes enter on rx_byte/frame_end, taken when push is high and full low.
// Each payload byte of the frame comes out as a kind 0 transaction; the byte
// with frame_end set gives a kind 1 verdict with status and header fields.
// Results leave as a queue: the oldest is on the output ports while empty is
// low and is taken when pop is high.
// A result is registered into the result queue when its byte is taken.
// Throughput: one byte per cycle while full is low; the byte-wide crc update
// sits in the front end's single stage, so a byte can follow every cycle.
// A stalled receiver fills the result queue (QUEUE_DEPTH entries); full then
// rises and input stalls until a transaction is popped. Bytes that give no
// result never need a queue slot but still wait on full.
// Reset clears the frame state, the queue and expected_id/expected_version.
// Registers (index 0 expected_id, index 1 expected_version) are written with
// wr_en/wr_index/wr_data; user's duty, unchecked: no frame or result in flight.
`default_nettype none

module frame_checker_crc32_top #(
	parameter int unsigned QUEUE_DEPTH = fcc_pkg::QUEUE_DEPTH
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic [7:0]                      rx_byte,
	input  wire logic                            frame_end,
	input  wire logic                            push,
	output logic                                 full,
	output logic                                 kind,
	output logic [7:0]                           payload_byte,
	output logic [2:0]                           status,
	output logic [15:0]                          seq_number,
	output logic [15:0]                          frame_total,
	output logic [15:0]                          declared_length,
	output logic                                 empty,
	input  wire logic                            pop,
	input  wire logic                            wr_en,
	input  wire logic [fcc_pkg::CFG_INDEX_W-1:0] wr_index,
	input  wire logic [fcc_pkg::CFG_DATA_W-1:0]  wr_data
);

	logic                q_push;
	logic                q_full;
	fcc_pkg::fcc_entry_t q_in;
	fcc_pkg::fcc_entry_t q_out;
	fcc_pkg::fcc_cfg_t   cfg;

	assign cfg.we    = wr_en;
	assign cfg.index = wr_index;
	assign cfg.data  = wr_data;

	// byte intake and classification
	fcc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx_byte   (rx_byte),
		.frame_end (frame_end),
		.push      (push),
		.full      (full),
		.q_push    (q_push),
		.q_entry   (q_in),
		.q_full    (q_full)
	);

	// result queue
	fcc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.entry_in  (q_in),
		.full      (q_full),
		.pop       (pop),
		.empty     (empty),
		.entry_out (q_out)
	);

	// verdict and output fields
	fcc_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg),
		.entry           (q_out),
		.kind            (kind),
		.payload_byte    (payload_byte),
		.status          (status),
		.seq_number      (seq_number),
		.frame_total     (frame_total),
		.declared_length (declared_length)
	);

endmodule

`default_nettype wire
